### rtl/bmsc_pkg.sv
// ----------------------------------------------------------------------------
// bmsc_pkg: shared definitions for the banded median stability check
// Sizes, register codes, the sequencer state type and the control bundle
// that the top level hands to every sorting cell.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsc_pkg;

  // Size of the sample store, one cell per sample.
  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int MD_W     = SAMPLE_W + 1;
  localparam int BOUND_W  = SAMPLE_W + 3;
  localparam int LIMIT_W  = 16;
  localparam int BAND_W   = 15;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_BAND  = 1'b1;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);
  localparam logic [BAND_W-1:0]  BAND_RESET  = BAND_W'(500);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_LOAD,
    S_DRAIN,
    S_MEDIAN,
    S_MID,
    S_BOUNDS,
    S_BAND,
    S_SPREAD,
    S_REPORT
  } state_t;

  // Control bundle for the cells.
  typedef struct packed {
    logic clear;
    logic rotate;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/bmsc_cell.sv
// ----------------------------------------------------------------------------
// bmsc_cell: one cell of the systolic insertion sorter
// Keeps the smaller of its value and the arriving one and hands the larger
// to the next cell. In rotate mode it takes its right neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsc_cell import bmsc_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic signed [SAMPLE_W-1:0] ins_val,
  input  wire                        ins_vld,
  input  wire logic signed [SAMPLE_W-1:0] rot_val,
  input  wire                        rot_vld,
  output logic signed [SAMPLE_W-1:0] val,
  output logic                       vld,
  output logic signed [SAMPLE_W-1:0] pass_val,
  output logic                       pass_vld
);

  // Held value. Payload has no reset.
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      val <= rot_val;
    end else if (!ctrl.clear && ins_vld && (!vld || ins_val < val)) begin
      val <= ins_val;
    end
  end

  // Forwarded value: the larger of the pair goes right.
  always_ff @(posedge clk) begin
    if (ins_vld && vld && ins_val < val) begin
      pass_val <= val;
    end else begin
      pass_val <= ins_val;
    end
  end

  // Occupancy and forward strobe.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      vld      <= 1'b0;
      pass_vld <= 1'b0;
    end else if (ctrl.rotate) begin
      vld      <= rot_vld;
      pass_vld <= 1'b0;
    end else begin
      if (ins_vld) begin
        vld <= 1'b1;
      end
      pass_vld <= ins_vld && vld;
    end
  end

endmodule

`default_nettype wire

### rtl/banded_median_stability_check.sv
// ----------------------------------------------------------------------------
// banded_median_stability_check: judges the stability of a sample set
// Sorts samples on the fly in a chain of cells, then rotates the chain to
// pick the median and to find the in-band max and min.
// ----------------------------------------------------------------------------
// Loading: one word per cycle while busy is low. Once the last word is taken
// the chain settles, is rotated to pick out the median, the band bounds are
// formed, a second rotation scans the band and the spread is formed; then done
// strobes. busy stays high through the done cycle.
// The receiver cannot stall. Reset clears the set, the cells and the sequencer
// and loads register defaults (limit 50, band half width 500).
`default_nettype none

module banded_median_stability_check import bmsc_pkg::*; (
  input  wire                        clk,
  input  wire                        rst,
  // Sample words
  input  wire                        start,
  output logic                       busy,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire                        last,
  // Result
  output logic                       done,
  output logic                       stable,
  output logic signed [MD_W-1:0]     median_doubled,
  output logic [LIMIT_W-1:0]         spread,
  output logic                       none_in_band,
  output logic                       overflow,
  // Configuration
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [PADDR_W-1:0]          paddr,
  input  wire [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  state_t state, state_next;

  logic [LIMIT_W-1:0] stability_limit;
  logic [BAND_W-1:0]  band_half_width;

  logic [CNT_W-1:0] count;
  logic             overflow_seen;
  logic [IDX_W-1:0] step;
  logic             step_end;
  logic             accept;

  cell_ctrl_t cell_ctrl;

  logic signed [SAMPLE_W-1:0] chain_val [MAX_SAMPLES+1];
  logic                       chain_vld [MAX_SAMPLES+1];
  logic signed [SAMPLE_W-1:0] cell_val  [MAX_SAMPLES];
  logic                       cell_vld  [MAX_SAMPLES];

  logic signed [SAMPLE_W-1:0] med_lo, med_hi;
  logic signed [MD_W-1:0]     md;
  logic signed [BOUND_W-1:0]  lo_bound, hi_bound;
  logic signed [SAMPLE_W-1:0] vmax, vmin;
  logic                       any;
  logic [LIMIT_W-1:0]         spread_r;

  logic [IDX_W-1:0]           half_lo, half_hi;
  logic                       in_set;
  logic signed [BOUND_W-1:0]  head_dbl;
  logic                       in_band;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stability_limit <= LIMIT_RESET;
      band_half_width <= BAND_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LIMIT: stability_limit <= pwdata[LIMIT_W-1:0];
        REG_BAND:  band_half_width <= pwdata[BAND_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LIMIT: prdata = PDATA_W'(stability_limit);
      REG_BAND:  prdata = PDATA_W'(band_half_width);
      default:   prdata = '0;
    endcase
  end

  // Sequencer: next state.
  assign accept   = start && !busy;
  assign step_end = (step == IDX_W'(MAX_SAMPLES - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (accept && last) state_next = S_DRAIN;
      S_DRAIN:  if (step_end) state_next = S_MEDIAN;
      S_MEDIAN: if (step_end) state_next = S_MID;
      S_MID:    state_next = S_BOUNDS;
      S_BOUNDS: state_next = S_BAND;
      S_BAND:   if (step_end) state_next = S_SPREAD;
      S_SPREAD: state_next = S_REPORT;
      S_REPORT: state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: outputs.
  always_comb begin
    busy             = 1'b1;
    done             = 1'b0;
    cell_ctrl.clear  = 1'b0;
    cell_ctrl.rotate = 1'b0;
    case (state)
      S_LOAD:   busy = 1'b0;
      S_MEDIAN: cell_ctrl.rotate = 1'b1;
      S_BAND:   cell_ctrl.rotate = 1'b1;
      S_REPORT: begin
        done            = 1'b1;
        cell_ctrl.clear = 1'b1;
      end
      default:  ;
    endcase
  end

  // Step counter for the drain wait and the two rotations.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == S_DRAIN || state == S_MEDIAN || state == S_BAND) begin
      step <= step + 1'b1;
    end else begin
      step <= '0;
    end
  end

  // Fill count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst || state == S_REPORT) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (count == CNT_W'(MAX_SAMPLES)) begin
        overflow_seen <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

  // Sorting chain: words enter at the head, the ring closes for rotation.
  assign chain_val[0] = sample;
  assign chain_vld[0] = accept && (count != CNT_W'(MAX_SAMPLES));

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    bmsc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .ins_val  (chain_val[i]),
      .ins_vld  (chain_vld[i]),
      .rot_val  (cell_val[(i + 1) % MAX_SAMPLES]),
      .rot_vld  (cell_vld[(i + 1) % MAX_SAMPLES]),
      .val      (cell_val[i]),
      .vld      (cell_vld[i]),
      .pass_val (chain_val[i+1]),
      .pass_vld (chain_vld[i+1])
    );
  end

  // The head cell shows sorted[step] during each rotation.
  assign half_hi  = IDX_W'(count >> 1);
  assign half_lo  = IDX_W'((count - 1'b1) >> 1);
  assign in_set   = (CNT_W'(step) < count);
  assign head_dbl = BOUND_W'(cell_val[0]) <<< 1;
  assign in_band  = in_set && (head_dbl > lo_bound) && (head_dbl < hi_bound);

  // Median pick, bounds and band scan.
  always_ff @(posedge clk) begin
    case (state)
      S_MEDIAN: begin
        if (step == half_lo) med_lo <= cell_val[0];
        if (step == half_hi) med_hi <= cell_val[0];
      end
      S_MID: begin
        md <= MD_W'(med_lo) + MD_W'(med_hi);
      end
      S_BOUNDS: begin
        lo_bound <= BOUND_W'(md) - BOUND_W'({band_half_width, 1'b0});
        hi_bound <= BOUND_W'(md) + BOUND_W'({band_half_width, 1'b0});
      end
      S_BAND: begin
        if (in_band) begin
          if (!any || cell_val[0] > vmax) vmax <= cell_val[0];
          if (!any || cell_val[0] < vmin) vmin <= cell_val[0];
        end
      end
      S_SPREAD: begin
        spread_r <= any ? LIMIT_W'(vmax - vmin) : '0;
      end
      default: ;
    endcase
  end

  // In-band hit flag, cleared before each scan.
  always_ff @(posedge clk) begin
    if (rst || state == S_BOUNDS) begin
      any <= 1'b0;
    end else if (state == S_BAND && in_band) begin
      any <= 1'b1;
    end
  end

  // Result word.
  assign stable         = (spread_r <= stability_limit);
  assign median_doubled = md;
  assign spread         = spread_r;
  assign none_in_band   = !any;
  assign overflow       = overflow_seen;

  // Checks.
  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    !chain_vld[MAX_SAMPLES])
    else $error("Sorting chain spilled a sample past its last cell.");

  a_judged_nonempty: assert property (@(posedge clk) disable iff (rst)
    done |-> (count != '0))
    else $error("A result was given for an empty set.");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> busy)
    else $error("The block stayed ready after the last word.");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |=> (!busy && count == '0 && !overflow_seen))
    else $error("The set was not cleared after its result.");

endmodule

`default_nettype wire
